### hdl/gcm_pkg.sv
package gcm_pkg;

  localparam int ID_W = 16;
  localparam int HANDLE_W = 16;

  typedef enum logic [1:0] {
    CMD_LOAD_MOTHER = 2'd0,
    CMD_LOAD_FATHER = 2'd1,
    CMD_START       = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_t;

  // packed gene: id, handle, frozen, coin
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic                frozen;
    logic                coin;
  } gene_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_RD,
    ST_SORT_KEY,
    ST_SORT_PRV,
    ST_SORT_CMP,
    ST_MRG_RD,
    ST_MRG_DEC,
    ST_DONE
  } state_t;

endpackage

### hdl/gcm_store.sv
// One parent's gene list: synchronous memory, one write and one read port.
module gcm_store #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  gcm_pkg::gene_t  wdata,
  input  logic [AW-1:0]   raddr,
  output gcm_pkg::gene_t  rdata
);
  import gcm_pkg::*;

  gene_t mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/genome_crossover_merge.sv
// Genome crossover merge.
// Input channel (in_valid/in_stall): cmd 0 loads a mother gene, cmd 1 a
// father gene, cmd 2 starts a crossover with both fitnesses, cmd 3 is
// ignored. Loads are taken one per cycle while in_stall is low; a load
// past MAX_GENES is dropped and flagged in the overflowed field of the
// next crossover's results. Start sorts each list in place by id with a
// stable insertion sort and then walks both lists in merged order, emitting
// one child word per kept gene; the final word carries last_gene, an empty
// child gives one word with child_empty set.
// Per list the sort fetches each key, then moves each larger element up
// one place at a time and then places the key; the merge reads one gene
// of each list per step of the walk, at most 2N steps for N genes. Both
// are paced by the single read port of each gene memory.
// in_stall is high from the accepted start until the last child word is
// taken; the next word can be accepted in the following cycle.
// Output channel (out_valid/out_stall): a word holds while out_stall is
// high, and the walk waits on it before its next step.
// Reset clears counts, overflow flag and control; memory contents are
// undefined until loaded.
module genome_crossover_merge #(
  parameter int MAX_GENES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [15:0]         gene_id,
  input  logic [15:0]         gene_handle,
  input  logic                gene_frozen,
  input  logic                coin,
  input  logic signed [31:0]  mother_fitness,
  input  logic signed [31:0]  father_fitness,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         child_gene_id,
  output logic [15:0]         child_gene_handle,
  output logic                child_frozen,
  output logic                from_strong,
  output logic                child_empty,
  output logic                overflowed,
  output logic                last_gene
);
  import gcm_pkg::*;

  localparam int AW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
  localparam int CW = $clog2(MAX_GENES + 1);

  state_t state, state_next;

  logic [CW-1:0] mcount, fcount;
  logic          ovf;
  logic          sel;        // sort pass: 0 mother, 1 father
  logic          strong_f;   // father is strong
  logic [CW-1:0] si;         // sort outer i / merge strong index
  logic [CW-1:0] sj;         // sort inner j
  logic [CW-1:0] wi;         // merge weak index
  gene_t         key;
  gene_t         pend;
  logic          pend_strong;
  logic          have_pend;

  // memory ports
  logic          m_we, f_we;
  logic [AW-1:0] m_waddr, f_waddr, m_raddr, f_raddr;
  gene_t         m_wdata, f_wdata, m_rdata, f_rdata;

  gcm_store #(.DEPTH(MAX_GENES), .AW(AW)) u_mother (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );
  gcm_store #(.DEPTH(MAX_GENES), .AW(AW)) u_father (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  logic          in_acc, out_acc, out_free;
  cmd_t          in_cmd;
  gene_t         in_gene;
  logic [CW-1:0] scnt, wcnt, sort_cnt;
  gene_t         sel_rd, s_rd, w_rd, pick;
  logic          w_ok, w_lt, w_eq, keep, pick_weak;
  logic          out_load;
  logic [15:0]   id_next, handle_next;
  logic          frozen_next, strong_next, empty_next, last_next;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign in_cmd = cmd_t'(cmd);
  assign in_gene = '{id: gene_id, handle: gene_handle, frozen: gene_frozen, coin: coin};
  assign sort_cnt = sel ? fcount : mcount;
  assign sel_rd = sel ? f_rdata : m_rdata;
  assign scnt = strong_f ? fcount : mcount;
  assign wcnt = strong_f ? mcount : fcount;
  assign s_rd = strong_f ? f_rdata : m_rdata;
  assign w_rd = strong_f ? m_rdata : f_rdata;

  // merge step decision on the two fetched genes
  assign w_ok = (wi < wcnt);
  assign w_lt = w_ok && (w_rd.id < s_rd.id);
  assign w_eq = w_ok && (w_rd.id == s_rd.id);
  assign keep = !w_lt && !(w_eq && s_rd.frozen);
  assign pick_weak = w_eq && !w_rd.frozen && !s_rd.coin;
  assign pick = pick_weak ? w_rd : s_rd;

  // memory write and read addressing
  always_comb begin
    m_we = 1'b0;
    f_we = 1'b0;
    m_waddr = mcount[AW-1:0];
    f_waddr = fcount[AW-1:0];
    m_wdata = in_gene;
    f_wdata = in_gene;
    m_raddr = si[AW-1:0];
    f_raddr = si[AW-1:0];
    case (state)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_LOAD_MOTHER && mcount < CW'(MAX_GENES)) m_we = 1'b1;
        if (in_acc && in_cmd == CMD_LOAD_FATHER && fcount < CW'(MAX_GENES)) f_we = 1'b1;
      end
      ST_SORT_PRV: begin
        // fetch a[j-1], or place the key at the bottom
        m_raddr = AW'(sj - 1'b1);
        f_raddr = AW'(sj - 1'b1);
        m_waddr = sj[AW-1:0];
        f_waddr = sj[AW-1:0];
        m_wdata = key;
        f_wdata = key;
        m_we = (sj == '0) && !sel;
        f_we = (sj == '0) && sel;
      end
      ST_SORT_CMP: begin
        // shift a[j-1] up, or place the key
        m_waddr = sj[AW-1:0];
        f_waddr = sj[AW-1:0];
        m_wdata = (sel_rd.id > key.id) ? sel_rd : key;
        f_wdata = m_wdata;
        m_we = !sel;
        f_we = sel;
      end
      ST_MRG_RD: begin
        if (strong_f) begin
          f_raddr = si[AW-1:0];
          m_raddr = wi[AW-1:0];
        end else begin
          m_raddr = si[AW-1:0];
          f_raddr = wi[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  // next state and output word
  always_comb begin
    state_next = state;
    out_load = 1'b0;
    id_next = pend.id;
    handle_next = pend.handle;
    frozen_next = pend.frozen;
    strong_next = pend_strong;
    empty_next = 1'b0;
    last_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_START) state_next = ST_SORT_RD;
      end
      ST_SORT_RD: begin
        if (si < sort_cnt) state_next = ST_SORT_KEY;
        else if (sel) state_next = ST_MRG_RD;
      end
      ST_SORT_KEY: state_next = ST_SORT_PRV;
      ST_SORT_PRV: state_next = (sj == '0) ? ST_SORT_RD : ST_SORT_CMP;
      ST_SORT_CMP: state_next = (sel_rd.id > key.id) ? ST_SORT_PRV : ST_SORT_RD;
      ST_MRG_RD: begin
        // wait for a free output register before each step
        if (out_free) begin
          if (si < scnt) begin
            state_next = ST_MRG_DEC;
          end else begin
            out_load = 1'b1;
            last_next = 1'b1;
            if (!have_pend) begin
              id_next = '0;
              handle_next = '0;
              frozen_next = 1'b0;
              strong_next = 1'b0;
              empty_next = 1'b1;
            end
            state_next = ST_DONE;
          end
        end
      end
      ST_MRG_DEC: begin
        // release the pending word once a newer one replaces it
        out_load = keep && have_pend;
        state_next = ST_MRG_RD;
      end
      ST_DONE: begin
        if (out_acc) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      mcount <= '0;
      fcount <= '0;
      ovf <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_cmd)
              CMD_LOAD_MOTHER: begin
                if (mcount < CW'(MAX_GENES)) mcount <= mcount + 1'b1;
                else ovf <= 1'b1;
              end
              CMD_LOAD_FATHER: begin
                if (fcount < CW'(MAX_GENES)) fcount <= fcount + 1'b1;
                else ovf <= 1'b1;
              end
              CMD_START: begin
                strong_f <= !(mother_fitness > father_fitness);
                sel <= 1'b0;
                si <= CW'(1);
                have_pend <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_SORT_RD: begin
          if (si >= sort_cnt) begin
            // this list done
            if (!sel) begin
              sel <= 1'b1;
              si <= CW'(1);
            end else begin
              si <= '0;
              wi <= '0;
            end
          end
        end
        ST_SORT_KEY: begin
          key <= sel_rd;
          sj <= si;
        end
        ST_SORT_PRV: begin
          if (sj == '0) si <= si + 1'b1;
        end
        ST_SORT_CMP: begin
          if (sel_rd.id > key.id) sj <= sj - 1'b1;
          else si <= si + 1'b1;
        end
        ST_MRG_DEC: begin
          if (w_lt) begin
            wi <= wi + 1'b1;
          end else begin
            si <= si + 1'b1;
            if (w_eq) wi <= wi + 1'b1;
            // hold the kept gene until the walk knows whether it is last
            if (keep) begin
              pend <= pick;
              pend_strong <= !pick_weak;
              have_pend <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_acc) begin
            mcount <= '0;
            fcount <= '0;
            ovf <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
    end
    if (out_load) begin
      child_gene_id <= id_next;
      child_gene_handle <= handle_next;
      child_frozen <= frozen_next;
      from_strong <= strong_next;
      child_empty <= empty_next;
      overflowed <= ovf;
      last_gene <= last_next;
    end
  end

endmodule
